### rtl/core/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  // table geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int META_BYTES = 32;
  localparam int SIZE_W     = 27;

  // request kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_ZALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;
  localparam logic [1:0] KIND_RESIZE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  // register map and reset values
  localparam logic REG_MAX_REQUEST = 1'b0;
  localparam logic REG_HEAP_LIMIT  = 1'b1;
  localparam logic [SIZE_W-1:0] MAX_REQUEST_RST = 27'd100000000;
  localparam logic [31:0]       HEAP_LIMIT_RST  = 32'd16777216;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [15:0] element_count;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [31:0]      result_address;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_block_count;
    logic [31:0]      free_byte_count;
    logic [CNT_W-1:0] allocated_block_count;
    logic [31:0]      allocated_byte_count;
  } out_t;

  typedef struct packed {
    logic [31:0]       start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } tbl_wr_t;

endpackage
`default_nettype wire

### rtl/core/ffba_table.sv
`default_nettype none
module ffba_table (
  input  wire                          clk,
  input  ffba_pkg::tbl_wr_t            wr,
  input  wire [ffba_pkg::IDX_W-1:0]    rd_idx,
  output ffba_pkg::entry_t             rd_data
);

  ffba_pkg::entry_t mem_r [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_q_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.ent;
    end
    rd_q_r <= mem_r[rd_idx];
  end

  assign rd_data = rd_q_r;

endmodule
`default_nettype wire

### rtl/core/ffba_match.sv
`default_nettype none
module ffba_match (
  input  wire                  fit_mode,
  input  wire [31:0]           key,
  input  wire                  key_ok,
  input  ffba_pkg::entry_t     ent,
  output logic                 match
);

  // fit mode: free block large enough; else start offset equals key
  always_comb begin
    if (fit_mode) begin
      match = ent.free && (ent.size >= key[ffba_pkg::SIZE_W-1:0]);
    end else begin
      match = key_ok && (ent.start == key);
    end
  end

endmodule
`default_nettype wire

### rtl/core/first_fit_block_allocator.sv
`default_nettype none
// First-fit block allocator with a 64-entry block table.
// Input channel in_valid/in_ready/in_data carries one request transaction
// (allocate, zeroed allocate, free, resize); output channel
// out_valid/out_ready/out_data returns exactly one result per request with
// the result address, a status and the four heap counters.
// Registers max_request (0x0) and heap_limit (0x4) sit on the APB port.
// Steps: S_PREP forms the product, S_CHK checks the size, then a table scan
// reads one entry per cycle through a registered read with an end test,
// an optional S_REL releases a block and S_DONE loads the output
// register. A resize that moves scans twice, first to find its block and
// then to allocate. The single table read port makes each scan sequential.
// One request is in flight at a time; in_ready is high only when idle, so
// no new request is accepted until the previous one has left S_DONE.
// The output register holds a finished result until out_ready; a new
// request may be accepted meanwhile but its result waits for the register.
// Synchronous reset empties the heap, clears the counters and restores the
// register defaults; the table contents need no clearing.
module first_fit_block_allocator (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  ffba_pkg::in_t    in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output ffba_pkg::out_t   out_data,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [2:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_LKP  = 3'd3;
  localparam logic [2:0] S_ALC  = 3'd4;
  localparam logic [2:0] S_REL  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int CW = ffba_pkg::CNT_W;
  localparam int SW = ffba_pkg::SIZE_W;
  localparam int IW = ffba_pkg::IDX_W;

  logic [2:0]    state_r, state_nxt;
  ffba_pkg::in_t req_r;
  logic [47:0]   size_r;
  logic [31:0]   tgt_r;
  logic          tgt_ok_r;
  logic          rel_pend_r;
  logic [31:0]   res_r;
  logic [1:0]    st_r;

  logic [SW-1:0] max_request_r;
  logic [31:0]   heap_limit_r;

  logic [CW-1:0] block_count_r;
  logic [31:0]   brk_r;
  logic [CW-1:0] free_blocks_r;
  logic [31:0]   free_sum_r;
  logic [31:0]   used_bytes_r;

  logic [CW-1:0] rd_idx_r;
  logic          vld_r;
  logic [IW-1:0] chk_idx_r;
  logic [IW-1:0] hold_idx_r;
  ffba_pkg::entry_t hold_ent_r;

  logic          out_valid_r;
  ffba_pkg::out_t out_r;

  ffba_pkg::entry_t  rd_ent;
  ffba_pkg::tbl_wr_t wr;
  logic          match;
  logic          issue;
  logic          scan_hit;
  logic          scan_miss;
  logic          scan_step;
  logic [SW-1:0] size27;
  logic          size_bad;
  logic [33:0]   app_end;
  logic          app_fail;
  logic          cfg_wr;

  assign size27   = size_r[SW-1:0];
  assign size_bad = (size_r == 48'd0) || (size_r > {{(48-SW){1'b0}}, max_request_r});
  assign issue    = rd_idx_r < block_count_r;
  assign scan_hit = vld_r && match;
  assign scan_miss = !vld_r && !issue;
  assign scan_step = ((state_r == S_LKP) || (state_r == S_ALC)) && !scan_hit && !scan_miss;
  assign app_end  = {2'b00, brk_r} + 34'(ffba_pkg::META_BYTES) + {7'd0, size27};
  assign app_fail = (block_count_r >= CW'(ffba_pkg::MAX_BLOCKS)) ||
                    (app_end > {2'b00, heap_limit_r});

  // block table and the shared entry matcher
  ffba_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (rd_idx_r[IW-1:0]),
    .rd_data (rd_ent)
  );

  ffba_match u_match (
    .fit_mode (state_r == S_ALC),
    .key      ((state_r == S_ALC) ? {{(32-SW){1'b0}}, size27} : tgt_r),
    .key_ok   (tgt_ok_r),
    .ent      (rd_ent),
    .match    (match)
  );

  // table writes: take a block, append, or release
  always_comb begin
    wr = '0;
    unique case (state_r)
      S_ALC: begin
        if (scan_hit) begin
          wr.en  = 1'b1;
          wr.idx = chk_idx_r;
          wr.ent = '{start: rd_ent.start, size: rd_ent.size, free: 1'b0};
        end else if (scan_miss && !app_fail) begin
          wr.en  = 1'b1;
          wr.idx = block_count_r[IW-1:0];
          wr.ent = '{start: brk_r, size: size27, free: 1'b0};
        end
      end
      S_REL: begin
        if (!hold_ent_r.free) begin
          wr.en  = 1'b1;
          wr.idx = hold_idx_r;
          wr.ent = '{start: hold_ent_r.start, size: hold_ent_r.size, free: 1'b1};
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PREP;
      S_PREP: state_nxt = S_CHK;
      S_CHK: begin
        priority if (req_r.kind == ffba_pkg::KIND_FREE) begin
          state_nxt = (req_r.address == 32'd0) ? S_DONE : S_LKP;
        end else if (size_bad) begin
          state_nxt = S_DONE;
        end else if (req_r.kind == ffba_pkg::KIND_RESIZE && req_r.address != 32'd0) begin
          state_nxt = S_LKP;
        end else begin
          state_nxt = S_ALC;
        end
      end
      S_LKP: begin
        if (scan_hit) begin
          priority if (req_r.kind == ffba_pkg::KIND_FREE) state_nxt = S_REL;
          else if (size27 <= rd_ent.size) state_nxt = S_DONE;
          else state_nxt = S_ALC;
        end else if (scan_miss) begin
          state_nxt = S_DONE;
        end
      end
      S_ALC: begin
        if (scan_hit || (scan_miss && !app_fail)) begin
          state_nxt = rel_pend_r ? S_REL : S_DONE;
        end else if (scan_miss) begin
          state_nxt = S_DONE;
        end
      end
      S_REL: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and heap state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_count_r <= '0;
      brk_r         <= '0;
      free_blocks_r <= '0;
      free_sum_r    <= '0;
      used_bytes_r  <= '0;
      rd_idx_r      <= '0;
      vld_r         <= 1'b0;
      rel_pend_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= scan_step && issue;
      out_valid_r <= (state_r == S_DONE) || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          rel_pend_r <= 1'b0;
          rd_idx_r   <= '0;
        end
        S_LKP: begin
          if (scan_hit) begin
            rd_idx_r <= '0;
            if (req_r.kind == ffba_pkg::KIND_RESIZE) begin
              rel_pend_r <= 1'b1;
            end
          end else if (!scan_miss) begin
            rd_idx_r <= rd_idx_r + CW'(issue);
          end
        end
        S_ALC: begin
          if (scan_hit) begin
            free_blocks_r <= free_blocks_r - CW'(1);
            free_sum_r    <= free_sum_r - {{(32-SW){1'b0}}, rd_ent.size};
          end else if (scan_miss) begin
            if (!app_fail) begin
              block_count_r <= block_count_r + CW'(1);
              used_bytes_r  <= used_bytes_r + {{(32-SW){1'b0}}, size27};
              brk_r         <= app_end[31:0];
            end
          end else begin
            rd_idx_r <= rd_idx_r + CW'(issue);
          end
        end
        S_REL: begin
          if (!hold_ent_r.free) begin
            free_blocks_r <= free_blocks_r + CW'(1);
            free_sum_r    <= free_sum_r + {{(32-SW){1'b0}}, hold_ent_r.size};
          end
        end
        default: begin
          rel_pend_r <= rel_pend_r;
        end
      endcase
    end
  end

  // request payload, scan bookkeeping and result
  always_ff @(posedge clk) begin
    chk_idx_r <= rd_idx_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_r <= in_data;
          res_r <= '0;
          st_r  <= ffba_pkg::ST_OK;
        end
      end
      S_PREP: begin
        if (req_r.kind == ffba_pkg::KIND_ZALLOC) begin
          size_r <= {16'd0, req_r.request_size} * {32'd0, req_r.element_count};
        end else begin
          size_r <= {16'd0, req_r.request_size};
        end
      end
      S_CHK: begin
        tgt_r    <= req_r.address - 32'(ffba_pkg::META_BYTES);
        tgt_ok_r <= req_r.address >= 32'(ffba_pkg::META_BYTES);
        if (req_r.kind != ffba_pkg::KIND_FREE && size_bad) begin
          st_r <= ffba_pkg::ST_BAD_SIZE;
        end
      end
      S_LKP: begin
        if (scan_hit) begin
          hold_idx_r <= chk_idx_r;
          hold_ent_r <= rd_ent;
          if (req_r.kind == ffba_pkg::KIND_RESIZE && size27 <= rd_ent.size) begin
            res_r <= req_r.address;
          end
        end else if (scan_miss) begin
          st_r <= ffba_pkg::ST_UNKNOWN;
        end
      end
      S_ALC: begin
        if (scan_hit) begin
          res_r <= rd_ent.start + 32'(ffba_pkg::META_BYTES);
        end else if (scan_miss) begin
          if (app_fail) begin
            st_r <= ffba_pkg::ST_NO_MEMORY;
          end else begin
            res_r <= brk_r + 32'(ffba_pkg::META_BYTES);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_r.result_address        <= res_r;
          out_r.status                <= st_r;
          out_r.free_block_count      <= free_blocks_r;
          out_r.free_byte_count       <= free_sum_r;
          out_r.allocated_block_count <= block_count_r;
          out_r.allocated_byte_count  <= used_bytes_r;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_request_r <= ffba_pkg::MAX_REQUEST_RST;
      heap_limit_r  <= ffba_pkg::HEAP_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ffba_pkg::REG_MAX_REQUEST) begin
        max_request_r <= pwdata[SW-1:0];
      end else begin
        heap_limit_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == ffba_pkg::REG_HEAP_LIMIT) begin
      prdata = heap_limit_r;
    end else begin
      prdata = {{(32-SW){1'b0}}, max_request_r};
    end
  end

  assign pready    = 1'b1;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_free_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    free_blocks_r <= block_count_r)
    else $error("free block count above block count");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> block_count_r >= $past(block_count_r))
    else $error("block count decreased");

  a_scan_valid: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (state_r == S_LKP || state_r == S_ALC))
    else $error("table read pending outside a scan");
`endif

endmodule
`default_nettype wire

### verif/first_fit_block_allocator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow heap state
  logic [31:0] blk_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
  logic blk_free [MAX_BLOCKS];
  int unsigned blk_cnt;
  logic [31:0] brk;
  logic [CNT_W-1:0] free_blks;
  logic [31:0] heap_free_sum;
  logic [31:0] used_bytes;
  logic [SIZE_W-1:0] max_req;
  logic [31:0] heap_lim;

  in_t pending_reqs[$];
  out_t expected_results[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;
  bit hold_request;

  // remembers whether the last rising edge accepted the offered item
  logic in_ready_seen;

  // addresses the stimulus can reference (tracked by request order)
  logic [31:0] known_addrs[$];
  int unsigned blk_cnt_pred;
  logic [31:0] pool_brk;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic bit size_bad(logic [63:0] sz);
    return sz == 64'd0 || sz > {37'd0, max_req};
  endfunction

  function automatic int find_block(logic [31:0] a);
    for (int i = 0; i < blk_cnt; i++)
      if ({1'b0, blk_start[i]} + 33'(META_BYTES) == {1'b0, a}) return i;
    return -1;
  endfunction

  // first fit reuse, else append at the break
  function automatic logic [1:0] heap_alloc(logic [31:0] sz, output logic [31:0] a);
    logic [33:0] tail;
    a = '0;
    for (int i = 0; i < blk_cnt; i++) begin
      if (blk_free[i] && {5'd0, blk_size[i]} >= sz) begin
        blk_free[i] = 1'b0;
        free_blks = free_blks - 1'b1;
        heap_free_sum = heap_free_sum - {5'd0, blk_size[i]};
        a = blk_start[i] + META_BYTES;
        return ST_OK;
      end
    end
    if (blk_cnt >= MAX_BLOCKS) return ST_NO_MEMORY;
    tail = {2'b0, brk} + 34'(META_BYTES) + {2'b0, sz};
    if (tail > {2'b0, heap_lim}) return ST_NO_MEMORY;
    blk_start[blk_cnt] = brk;
    blk_size[blk_cnt] = sz[SIZE_W-1:0];
    blk_free[blk_cnt] = 1'b0;
    blk_cnt++;
    used_bytes = used_bytes + sz;
    a = brk + META_BYTES;
    brk = tail[31:0];
    return ST_OK;
  endfunction

  function automatic void mark_free(int i);
    if (!blk_free[i]) begin
      blk_free[i] = 1'b1;
      free_blks = free_blks + 1'b1;
      heap_free_sum = heap_free_sum + {5'd0, blk_size[i]};
    end
  endfunction

  function automatic out_t predict_heap(in_t r);
    out_t o;
    logic [63:0] prod;
    logic [31:0] a;
    int i;
    o = '0;
    a = '0;
    case (r.kind)
      KIND_ALLOC: begin
        if (size_bad({32'd0, r.request_size})) o.status = ST_BAD_SIZE;
        else o.status = heap_alloc(r.request_size, a);
      end
      KIND_ZALLOC: begin
        prod = {32'd0, r.request_size} * {48'd0, r.element_count};
        if (size_bad(prod)) o.status = ST_BAD_SIZE;
        else o.status = heap_alloc(prod[31:0], a);
      end
      KIND_FREE: begin
        if (r.address != 0) begin
          i = find_block(r.address);
          if (i < 0) o.status = ST_UNKNOWN;
          else mark_free(i);
        end
      end
      default: begin
        if (size_bad({32'd0, r.request_size})) o.status = ST_BAD_SIZE;
        else if (r.address == 0) o.status = heap_alloc(r.request_size, a);
        else begin
          i = find_block(r.address);
          if (i < 0) o.status = ST_UNKNOWN;
          else if (r.request_size <= {5'd0, blk_size[i]}) a = r.address;
          else begin
            o.status = heap_alloc(r.request_size, a);
            if (o.status == ST_OK) mark_free(i);
          end
        end
      end
    endcase
    o.result_address = a;
    o.free_block_count = free_blks;
    o.free_byte_count = heap_free_sum;
    o.allocated_block_count = CNT_W'(blk_cnt);
    o.allocated_byte_count = used_bytes;
    return o;
  endfunction

  // driver: one transaction per handshake
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input acceptance and prediction
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_results.push_back(predict_heap(in_data));
  end

  // receiver readiness
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (hold_request) begin
      out_ready <= 1'b0;
      recv_hold <= 400;
      hold_request <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.result_address !== exp_r.result_address ||
            out_data.status !== exp_r.status ||
            out_data.free_block_count !== exp_r.free_block_count ||
            out_data.free_byte_count !== exp_r.free_byte_count ||
            out_data.allocated_block_count !== exp_r.allocated_block_count ||
            out_data.allocated_byte_count !== exp_r.allocated_byte_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, out_data);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] a, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (a == 3'(4 * REG_HEAP_LIMIT)) heap_lim = v;
    else max_req = v[SIZE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_heap();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // pick an address: mostly live blocks, sometimes junk or zero
  function automatic logic [31:0] pick_addr();
    int unsigned p;
    p = $urandom_range(99);
    if (blk_cnt_pred > 0 && p < 75)
      return known_addrs[$urandom_range(known_addrs.size() - 1)];
    if (p < 85) return 32'd0;
    if (p < 92) return $urandom_range(3) * 32'h40000000 + $urandom;
    return $urandom;
  endfunction

  function automatic in_t make_req(logic [1:0] k, logic [31:0] sz, logic [15:0] n,
                                   logic [31:0] a);
    in_t r;
    r.kind = k;
    r.request_size = sz;
    r.element_count = n;
    r.address = a;
    return r;
  endfunction

  function automatic logic [31:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 4096);
    if (p < 85) return $urandom_range(1, 262144);
    if (p < 92) return $urandom;
    if (p < 96) return 32'd0;
    return {5'd0, 27'h7ffffff};
  endfunction

  task automatic random_phase(int n);
    in_t r;
    logic [1:0] k;
    for (int j = 0; j < n; j++) begin
      k = 2'($urandom_range(3));
      case (k)
        KIND_ZALLOC: begin
          if ($urandom_range(9) < 8)
            r = make_req(k, $urandom_range(0, 512), 16'($urandom_range(0, 64)), $urandom);
          else r = make_req(k, $urandom, 16'($urandom), $urandom);
        end
        KIND_FREE, KIND_RESIZE: r = make_req(k, rand_size(), 16'($urandom), pick_addr());
        default: r = make_req(k, rand_size(), 16'($urandom), $urandom);
      endcase
      pending_reqs.push_back(r);
      // grow the address pool optimistically from the append pattern
      if (k != KIND_FREE && known_addrs.size() < 200) begin
        known_addrs.push_back(pool_brk + META_BYTES);
        pool_brk = pool_brk + META_BYTES + r.request_size;
        blk_cnt_pred++;
      end
    end
  endtask

  task automatic refresh_pool();
    known_addrs.delete();
    for (int i = 0; i < blk_cnt; i++) known_addrs.push_back(blk_start[i] + META_BYTES);
    blk_cnt_pred = blk_cnt;
    pool_brk = brk;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ready_seen = 1'b0;
    mismatches = 0;
    recv_hold = 0;
    hold_request = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 67;
    blk_cnt = 0;
    brk = '0;
    free_blks = '0;
    heap_free_sum = '0;
    used_bytes = '0;
    max_req = MAX_REQUEST_RST;
    heap_lim = HEAP_LIMIT_RST;
    blk_cnt_pred = 0;
    pool_brk = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes, each kind and special cases
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd0, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'hffffffff, 16'hffff, 32'hffffffff));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd100000001, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd100, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd1, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ZALLOC, 32'd16, 16'd4, 32'd0));
    pending_reqs.push_back(make_req(KIND_ZALLOC, 32'hffffffff, 16'hffff, 32'd0));
    pending_reqs.push_back(make_req(KIND_ZALLOC, 32'd5, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 32'd0, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 32'd0, 16'd0, 32'd32));
    pending_reqs.push_back(make_req(KIND_FREE, 32'd0, 16'd0, 32'd32));
    pending_reqs.push_back(make_req(KIND_FREE, 32'd0, 16'd0, 32'd33));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd50, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 32'd0, 16'd0, 32'd32));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd80, 16'd0, 32'd32));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd500, 16'd0, 32'd32));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd20, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd20, 16'd0, 32'hdeadbeef));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd0, 16'd0, 32'd164));
    pending_reqs.push_back(make_req(KIND_RESIZE, 32'd99999999, 16'd0, 32'd164));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd20000000, 16'd0, 32'd0));
    drain_heap();

    // phase one, with a long receiver stall
    refresh_pool();
    random_phase(200);
    hold_request = 1'b1;
    random_phase(150);
    drain_heap();

    // tight limits, extremes of both registers
    write_reg(3'(4 * REG_MAX_REQUEST), 32'd1);
    write_reg(3'(4 * REG_HEAP_LIMIT), 32'd0);
    rst_heap_free_phase();
    write_reg(3'(4 * REG_MAX_REQUEST), 32'd300);
    write_reg(3'(4 * REG_HEAP_LIMIT), brk + 32'd2000);
    refresh_pool();
    random_phase(200);
    drain_heap();

    send_idle_pct = 67;
    recv_idle_pct = 31;
    write_reg(3'(4 * REG_MAX_REQUEST), 32'h07ffffff);
    write_reg(3'(4 * REG_HEAP_LIMIT), 32'hffffffff);
    refresh_pool();
    random_phase(350);
    drain_heap();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(3'(4 * REG_MAX_REQUEST), 32'd5000);
    refresh_pool();
    random_phase(350);
    drain_heap();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // a few requests under the tightest limits
  task automatic rst_heap_free_phase();
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd1, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 32'd2, 16'd0, 32'd0));
    pending_reqs.push_back(make_req(KIND_ZALLOC, 32'd1, 16'd1, 32'd0));
    drain_heap();
  endtask

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
